// ===== rtl/vfm_pkg.sv =====
// ---------------------------------------------------------------------------
// vfm_pkg
// Shared types, codes and corner tables of the voxel face mesher.
// ---------------------------------------------------------------------------
package vfm_pkg;

    // chunk extent
    localparam int SIZE_X = 16;
    localparam int SIZE_Y = 128;
    localparam int SIZE_Z = 16;

    localparam int NUM_FACES = 6;
    localparam int NUM_VERTS = 6;

    typedef logic [0:0] t_cmd;
    localparam t_cmd CMD_LOAD = 1'b0;
    localparam t_cmd CMD_MESH = 1'b1;

    typedef logic [2:0] t_face;
    localparam t_face FACE_NZ = 3'd0;
    localparam t_face FACE_PZ = 3'd1;
    localparam t_face FACE_NX = 3'd2;
    localparam t_face FACE_PX = 3'd3;
    localparam t_face FACE_NY = 3'd4;
    localparam t_face FACE_PY = 3'd5;

    localparam logic [2:0] VERT_LAST = 3'd5;

    // one queued request
    typedef struct packed {
        logic        is_load;
        logic        kind_ok;
        logic [7:0]  kind;
        t_face       face_sel;
        logic [7:0]  base_u;
        logic [7:0]  base_v;
        logic [3:0]  pos_x;
        logic [6:0]  pos_y;
        logic [3:0]  pos_z;
        logic [5:0]  keep;
    } t_job;

    // per corner offsets
    typedef struct packed {
        logic dx;
        logic dy;
        logic dz;
        logic du;
        logic dv;
    } t_ofs;

    // {dx, dy, dz, du, dv} for quad corners 0..3 of each face
    localparam logic [4:0] CORNER_OFS [24] = '{
        5'b00010, 5'b10000, 5'b11001, 5'b01011,
        5'b01101, 5'b11111, 5'b10110, 5'b00100,
        5'b00000, 5'b01001, 5'b01111, 5'b00110,
        5'b10100, 5'b11101, 5'b11011, 5'b10010,
        5'b00000, 5'b00101, 5'b10111, 5'b10010,
        5'b11011, 5'b11110, 5'b01100, 5'b01001
    };

    // vertex 0..5 walks quad corners 0,1,2,2,3,0
    function automatic t_ofs corner_ofs(input t_face face, input logic [2:0] vert);
        logic [1:0] q;
        unique case (vert)
            3'd0:    q = 2'd0;
            3'd1:    q = 2'd1;
            3'd2:    q = 2'd2;
            3'd3:    q = 2'd2;
            3'd4:    q = 2'd3;
            default: q = 2'd0;
        endcase
        return t_ofs'(CORNER_OFS[{face, q}]);
    endfunction

    // kind * 6 + face
    function automatic logic [10:0] tex_index(input logic [7:0] kind, input t_face face);
        return ({3'b000, kind} << 2) + ({3'b000, kind} << 1) + {8'b0, face};
    endfunction

endpackage

// ===== rtl/voxel_face_mesher_core.sv =====
// ---------------------------------------------------------------------------
// voxel_face_mesher_core
// Face culling mesher: loads texture bases and emits six vertices per
// visible face of a solid block.
//
//   channel  | dir | payload                          | accepted when
//   ---------+-----+----------------------------------+------------------
//   s_axis   | in  | tuser cmd, tdata block request   | tvalid & tready
//   m_axis   | out | tdata vertex, tlast block end    | tvalid & tready
//
// a mesh request with k visible faces gives six vertices per face at the vertex
// stage, one vertex per cycle through the output register unless m_axis stalls
// a load request is handled in the back part (table write)
// culled, non-solid and ignored requests never enter the queue
// a two entry queue decouples input acceptance from vertex output
// synchronous active-low reset clears control state; table is unwritten
// ---------------------------------------------------------------------------
module voxel_face_mesher_core
    import vfm_pkg::*;
#(
    parameter int BLOCK_KINDS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // pos_x[3:0] pos_y[10:4] pos_z[14:11] block_kind[22:15] face_sel[25:23]
    // base_u[33:26] base_v[41:34] is_solid[42] neighbour_solid[48:43]
    // side_chunk_loaded[52:49]
    input  logic [55:0] i_s_axis_tdata,
    // cmd[0]
    input  logic        i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // vert_x[4:0] vert_y[12:5] vert_z[17:13] tex_u[25:18] tex_v[33:26]
    // face_out[36:34]
    output logic [39:0] o_m_axis_tdata,
    // last_vertex
    output logic        o_m_axis_tlast
);

    logic q_full;
    logic q_push;
    logic q_valid;
    logic q_pop;
    t_job push_job;
    t_job head_job;

    vfm_front #(
        .BLOCK_KINDS (BLOCK_KINDS)
    ) u_front (
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_data   (i_s_axis_tdata),
        .i_user   (i_s_axis_tuser),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_job    (push_job)
    );

    vfm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (head_job),
        .i_pop   (q_pop)
    );

    vfm_back #(
        .BLOCK_KINDS (BLOCK_KINDS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_job   (head_job),
        .o_q_pop   (q_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_data    (o_m_axis_tdata),
        .o_last    (o_m_axis_tlast)
    );

endmodule

// ===== rtl/vfm_ram.sv =====
// ---------------------------------------------------------------------------
// vfm_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module vfm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1536,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/vfm_front.sv =====
// ---------------------------------------------------------------------------
// vfm_front
// Accepts requests, unpacks them and works out the visible face mask.
// ---------------------------------------------------------------------------
module vfm_front
    import vfm_pkg::*;
#(
    parameter int BLOCK_KINDS = 256
) (
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [55:0] i_data,
    input  logic        i_user,
    input  logic        i_q_full,
    output logic        o_push,
    output t_job        o_job
);

    localparam logic [8:0] SZ_X = 9'(SIZE_X);
    localparam logic [8:0] SZ_Y = 9'(SIZE_Y);
    localparam logic [8:0] SZ_Z = 9'(SIZE_Z);
    localparam logic [8:0] KINDS = 9'(BLOCK_KINDS);

    logic [3:0] pos_x;
    logic [6:0] pos_y;
    logic [3:0] pos_z;
    logic [7:0] kind;
    t_face      face_sel;
    logic       is_solid;
    logic [5:0] nsolid;
    logic [3:0] loaded;
    logic [8:0] px, py, pz;
    logic       in_x, in_y, in_z;
    logic       lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
    logic [5:0] at_edge;
    logic [5:0] keep;
    logic       kind_ok;
    logic       load_ok;

    assign pos_x    = i_data[3:0];
    assign pos_y    = i_data[10:4];
    assign pos_z    = i_data[14:11];
    assign kind     = i_data[22:15];
    assign face_sel = i_data[25:23];
    assign is_solid = i_data[42];
    assign nsolid   = i_data[48:43];
    assign loaded   = i_data[52:49];

    assign px = {5'b0, pos_x};
    assign py = {2'b0, pos_y};
    assign pz = {5'b0, pos_z};

    assign in_x = px < SZ_X;
    assign in_y = py < SZ_Y;
    assign in_z = pz < SZ_Z;
    assign lo_x = (px == 9'd0) || ((px - 9'd1) >= SZ_X);
    assign lo_y = (py == 9'd0) || ((py - 9'd1) >= SZ_Y);
    assign lo_z = (pz == 9'd0) || ((pz - 9'd1) >= SZ_Z);
    assign hi_x = (px + 9'd1) >= SZ_X;
    assign hi_y = (py + 9'd1) >= SZ_Y;
    assign hi_z = (pz + 9'd1) >= SZ_Z;

    always_comb begin
        at_edge[FACE_NZ] = lo_z || !in_x || !in_y;
        at_edge[FACE_PZ] = hi_z || !in_x || !in_y;
        at_edge[FACE_NX] = lo_x || !in_y || !in_z;
        at_edge[FACE_PX] = hi_x || !in_y || !in_z;
        at_edge[FACE_NY] = lo_y || !in_x || !in_z;
        at_edge[FACE_PY] = hi_y || !in_x || !in_z;
        // side faces: open neighbour, or unloaded neighbour chunk at the edge
        for (int f = 0; f < 4; f++) begin
            keep[f] = !nsolid[f] || (at_edge[f] && !loaded[f]);
        end
        // bottom and top: always shown at the edge
        keep[FACE_NY] = at_edge[FACE_NY] || !nsolid[FACE_NY];
        keep[FACE_PY] = at_edge[FACE_PY] || !nsolid[FACE_PY];
    end

    assign kind_ok = {1'b0, kind} < KINDS;
    assign load_ok = kind_ok && (face_sel <= FACE_PY);

    assign o_ready = !i_q_full;

    always_comb begin
        o_push = 1'b0;
        if (i_valid && o_ready) begin
            if (i_user == CMD_LOAD) begin
                o_push = load_ok;
            end else begin
                o_push = is_solid && (keep != 6'd0);
            end
        end
    end

    always_comb begin
        o_job.is_load  = (i_user == CMD_LOAD);
        o_job.kind_ok  = kind_ok;
        o_job.kind     = kind;
        o_job.face_sel = face_sel;
        o_job.base_u   = i_data[33:26];
        o_job.base_v   = i_data[41:34];
        o_job.pos_x    = pos_x;
        o_job.pos_y    = pos_y;
        o_job.pos_z    = pos_z;
        o_job.keep     = keep;
    end

endmodule

// ===== rtl/vfm_queue.sv =====
// ---------------------------------------------------------------------------
// vfm_queue
// Two entry request queue between the front and back parts.
// ---------------------------------------------------------------------------
module vfm_queue
    import vfm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    output t_job o_job,
    input  logic i_pop
);

    t_job       r_slot [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_push;
        n_rd_ptr = r_rd_ptr ^ i_pop;
        n_count  = r_count + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ===== rtl/vfm_back.sv =====
// ---------------------------------------------------------------------------
// vfm_back
// Executes queued requests: table writes, face issue and vertex output.
// ---------------------------------------------------------------------------
module vfm_back
    import vfm_pkg::*;
#(
    parameter int BLOCK_KINDS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_job        i_q_job,
    output logic        o_q_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [39:0] o_data,
    output logic        o_last
);

    localparam int DEPTH = BLOCK_KINDS * NUM_FACES;
    localparam int AW    = $clog2(DEPTH);

    // block being walked face by face
    logic       r_cur_valid, n_cur_valid;
    logic [5:0] r_cur_mask, n_cur_mask;
    logic       r_cur_kind_ok;
    logic [7:0] r_cur_kind;
    logic [3:0] r_cur_x;
    logic [6:0] r_cur_y;
    logic [3:0] r_cur_z;

    // face being emitted vertex by vertex
    logic       r_vs_valid, n_vs_valid;
    logic [2:0] r_vs_vert, n_vs_vert;
    t_face      r_vs_face;
    logic       r_vs_kind_ok;
    logic       r_vs_last;
    logic [3:0] r_vs_x;
    logic [6:0] r_vs_y;
    logic [3:0] r_vs_z;

    logic        r_out_valid, n_out_valid;
    logic [39:0] r_out_data;
    logic        r_out_last;

    logic        out_adv;
    logic        vs_fire;
    logic        vs_done;
    logic        slot_free;
    logic        issue;
    logic        pop;
    t_face       pick;
    logic [5:0]  mask_after;
    logic        ram_we;
    logic        ram_re;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    logic [15:0] ram_wdata;
    logic [15:0] ram_rdata;
    logic [7:0]  bu, bv;
    t_ofs        ofs;
    logic [4:0]  vx, vz;
    logic [7:0]  vy, tu, tv;

    assign out_adv   = !r_out_valid || i_ready;
    assign vs_fire   = r_vs_valid && out_adv;
    assign vs_done   = vs_fire && (r_vs_vert == VERT_LAST);
    assign slot_free = !r_vs_valid || vs_done;
    assign issue     = r_cur_valid && slot_free;
    assign pop       = i_q_valid && !r_cur_valid;
    assign o_q_pop   = pop;

    always_comb begin
        pick = FACE_NZ;
        for (int i = NUM_FACES - 1; i >= 0; i--) begin
            if (r_cur_mask[i]) begin
                pick = t_face'(i);
            end
        end
    end

    assign mask_after = r_cur_mask & (r_cur_mask - 6'd1);

    assign ram_we    = pop && i_q_job.is_load;
    assign ram_waddr = AW'(tex_index(i_q_job.kind, i_q_job.face_sel));
    assign ram_wdata = {i_q_job.base_v, i_q_job.base_u};
    assign ram_re    = issue && r_cur_kind_ok;
    assign ram_raddr = AW'(tex_index(r_cur_kind, pick));

    vfm_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_tex_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // unknown kinds read as a zero base
    assign bu = r_vs_kind_ok ? ram_rdata[7:0]  : 8'd0;
    assign bv = r_vs_kind_ok ? ram_rdata[15:8] : 8'd0;

    assign ofs = corner_ofs(r_vs_face, r_vs_vert);
    assign vx  = {1'b0, r_vs_x} + {4'b0, ofs.dx};
    assign vy  = {1'b0, r_vs_y} + {7'b0, ofs.dy};
    assign vz  = {1'b0, r_vs_z} + {4'b0, ofs.dz};
    assign tu  = bu + {7'b0, ofs.du};
    assign tv  = bv + {7'b0, ofs.dv};

    always_comb begin
        n_cur_valid = r_cur_valid;
        n_cur_mask  = r_cur_mask;
        if (issue) begin
            n_cur_mask  = mask_after;
            n_cur_valid = (mask_after != 6'd0);
        end else if (pop && !i_q_job.is_load) begin
            n_cur_valid = 1'b1;
            n_cur_mask  = i_q_job.keep;
        end
    end

    always_comb begin
        n_vs_valid = r_vs_valid;
        n_vs_vert  = r_vs_vert;
        if (issue) begin
            n_vs_valid = 1'b1;
            n_vs_vert  = 3'd0;
        end else if (vs_done) begin
            n_vs_valid = 1'b0;
        end else if (vs_fire) begin
            n_vs_vert = r_vs_vert + 3'd1;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (vs_fire) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_cur_mask  <= 6'd0;
            r_vs_valid  <= 1'b0;
            r_vs_vert   <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_cur_valid <= n_cur_valid;
            r_cur_mask  <= n_cur_mask;
            r_vs_valid  <= n_vs_valid;
            r_vs_vert   <= n_vs_vert;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && !i_q_job.is_load) begin
            r_cur_kind_ok <= i_q_job.kind_ok;
            r_cur_kind    <= i_q_job.kind;
            r_cur_x       <= i_q_job.pos_x;
            r_cur_y       <= i_q_job.pos_y;
            r_cur_z       <= i_q_job.pos_z;
        end
        if (issue) begin
            r_vs_face    <= pick;
            r_vs_kind_ok <= r_cur_kind_ok;
            r_vs_last    <= (mask_after == 6'd0);
            r_vs_x       <= r_cur_x;
            r_vs_y       <= r_cur_y;
            r_vs_z       <= r_cur_z;
        end
        if (vs_fire) begin
            r_out_data <= {3'b000, r_vs_face, tv, tu, vz, vy, vx};
            r_out_last <= r_vs_last && (r_vs_vert == VERT_LAST);
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_last  = r_out_last;

endmodule

// ===== rtl/vfm_checker.sv =====
// ---------------------------------------------------------------------------
// vfm_checker
// Port level checks on the vertex stream of the mesher core.
// ---------------------------------------------------------------------------
module vfm_checker
    import vfm_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [39:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);

    // stalled vertex holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("vertex changed while stalled");

    // face index is a real face
    a_face_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[36:34] <= FACE_PY)
        else $error("face index out of range");

    // corners stay one step from the block
    a_coord_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[4:0] <= 5'd16) &&
            (o_m_axis_tdata[12:5] <= 8'd128) && (o_m_axis_tdata[17:13] <= 5'd16))
        else $error("vertex coordinate out of range");

    // faces of one block come out in ascending order
    a_face_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast |=>
            !o_m_axis_tvalid || (o_m_axis_tdata[36:34] >= $past(o_m_axis_tdata[36:34])))
        else $error("face order broken within a block");

endmodule

bind voxel_face_mesher_core vfm_checker u_vfm_checker (.*);
